@@ design/cbm_pkg.sv @@
package cbm_pkg;

  // mapper kinds
  localparam logic [1:0] MAPPER_NONE = 2'd0;
  localparam logic [1:0] MAPPER_MBC1 = 2'd1;
  localparam logic [1:0] MAPPER_MBC2 = 2'd2;
  localparam logic [1:0] MAPPER_MBC3 = 2'd3;

  // result targets
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_ROM  = 3'd1;
  localparam logic [2:0] TGT_RAM  = 3'd2;
  localparam logic [2:0] TGT_MBC2 = 3'd3;
  localparam logic [2:0] TGT_RTC  = 3'd4;
  localparam logic [2:0] TGT_OPEN = 3'd5;

  // configuration register indexes
  localparam logic REG_MAPPER_KIND   = 1'b0;
  localparam logic REG_ROM_SIZE_LOG2 = 1'b1;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam int EXT_RAM_BYTES_DEF = 32768;

  localparam logic [4:0] ROM_LOG2_MIN = 5'd15;
  localparam logic [4:0] ROM_LOG2_MAX = 5'd23;
  localparam logic [4:0] ROM_LOG2_RST = 5'd15;

  typedef struct packed {
    logic [1:0] mapper_kind;
    logic [4:0] rom_size_log2;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [22:0] physical_address;
    logic [2:0]  rtc_index;
    logic [7:0]  store_data;
    logic        store_enable;
    logic        high_nibble_fill;
    logic        ram_disabled_event;
    logic        rtc_latch_strobe;
  } result_t;

  typedef struct packed {
    logic [6:0] rom_bank;
    logic [2:0] ram_bank;
    logic       ram_enable;
    logic       banking_mode;
    logic [3:0] rtc_select;
    logic [7:0] last_latch_write;
  } state_t;

endpackage

@@ design/cbm_req_if.sv @@
interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] bus_address;
  logic [7:0]  bus_data;

  modport source (output valid, output opcode, output bus_address, output bus_data,
                  input ready);
  modport sink (input valid, input opcode, input bus_address, input bus_data,
                output ready);
endinterface

@@ design/cbm_rsp_if.sv @@
interface cbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [22:0] physical_address;
  logic [2:0]  rtc_index;
  logic [7:0]  store_data;
  logic        store_enable;
  logic        high_nibble_fill;
  logic        ram_disabled_event;
  logic        rtc_latch_strobe;

  modport source (output valid, output target, output physical_address, output rtc_index,
                  output store_data, output store_enable, output high_nibble_fill,
                  output ram_disabled_event, output rtc_latch_strobe, input ready);
  modport sink (input valid, input target, input physical_address, input rtc_index,
                input store_data, input store_enable, input high_nibble_fill,
                input ram_disabled_event, input rtc_latch_strobe, output ready);
endinterface

@@ design/cbm_map.sv @@
module cbm_map #(
  parameter int EXT_RAM_BYTES = cbm_pkg::EXT_RAM_BYTES_DEF
) (
  input  cbm_pkg::cfg_t    cfg,
  input  cbm_pkg::state_t  st,
  input  cbm_pkg::item_t   item,
  output cbm_pkg::result_t res,
  output cbm_pkg::state_t  st_next
);
  import cbm_pkg::*;

  logic [15:0] a;
  logic [7:0]  d;
  logic [4:0]  lg;
  logic [23:0] rom_span;
  logic [23:0] rom_mask;
  logic [23:0] low_off;
  logic [23:0] high_off;
  logic [15:0] ram_off;
  logic        en_new;
  logic        rtc_sel_ok;

  assign a = item.bus_address;
  assign d = item.bus_data;

  always_comb begin
    lg = cfg.rom_size_log2;
    if (lg < ROM_LOG2_MIN) lg = ROM_LOG2_MIN;
    if (lg > ROM_LOG2_MAX) lg = ROM_LOG2_MAX;
  end

  assign rom_span = 24'd1 << lg;
  assign rom_mask = rom_span - 24'd1;

  // MBC1 mode 1 low area: bank = ram_bank << 5
  assign low_off  = (cfg.mapper_kind == MAPPER_MBC1 && st.banking_mode) ?
                    ({2'b00, st.ram_bank, 19'd0} + {8'd0, a}) : {8'd0, a};
  assign high_off = {3'b000, st.rom_bank, a[13:0]};
  assign ram_off  = {st.ram_bank, a[12:0]};
  assign en_new   = (d[3:0] == 4'hA);
  assign rtc_sel_ok = (st.rtc_select >= 4'h8) && (st.rtc_select <= 4'hC);

  always_comb begin
    st_next = st;
    res     = '0;
    res.target = TGT_NONE;

    if (!a[15]) begin
      if (item.opcode) begin
        case (cfg.mapper_kind)
          MAPPER_MBC1: begin
            if (a[14:13] == 2'b00) begin
              st_next.ram_enable = en_new;
              res.ram_disabled_event = st.ram_enable & ~en_new;
            end else if (a[14:13] == 2'b01) begin
              st_next.rom_bank[4:0] = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
            end else if (a[14:13] == 2'b10) begin
              st_next.ram_bank = {1'b0, d[1:0]};
              st_next.rom_bank[6:5] = d[1:0];
            end else begin
              st_next.banking_mode = d[0];
            end
          end
          MAPPER_MBC2: begin
            if (!a[14]) begin
              if (!a[8]) begin
                st_next.ram_enable = en_new;
                res.ram_disabled_event = st.ram_enable & ~en_new;
              end else begin
                st_next.rom_bank = {3'b000, (d[3:0] == 4'd0) ? 4'd1 : d[3:0]};
              end
            end
          end
          MAPPER_MBC3: begin
            if (a[14:13] == 2'b00) begin
              st_next.ram_enable = en_new;
              res.ram_disabled_event = st.ram_enable & ~en_new;
            end else if (a[14:13] == 2'b01) begin
              st_next.rom_bank = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
            end else if (a[14:13] == 2'b10) begin
              if (d <= 8'h07) begin
                st_next.ram_bank   = d[2:0];
                st_next.rtc_select = 4'h0;
              end else if (d <= 8'h0C) begin
                st_next.rtc_select = d[3:0];
              end
            end else begin
              res.rtc_latch_strobe = (st.last_latch_write == 8'h00) && (d == 8'h01);
              st_next.last_latch_write = d;
            end
          end
          default: begin
          end
        endcase
      end else if (!a[14]) begin
        res.target = TGT_ROM;
        res.physical_address = low_off[22:0] & rom_mask[22:0];
      end else if (high_off < rom_span) begin
        res.target = TGT_ROM;
        res.physical_address = high_off[22:0];
      end else begin
        res.target = TGT_OPEN;
      end
    end else if (a[15:13] == 3'b101) begin
      if (!st.ram_enable) begin
        res.target = TGT_OPEN;
      end else if (cfg.mapper_kind == MAPPER_MBC2) begin
        res.target = TGT_MBC2;
        res.physical_address = {14'd0, a[8:0]};
        if (item.opcode) begin
          res.store_data   = {4'h0, d[3:0]};
          res.store_enable = 1'b1;
        end else begin
          res.high_nibble_fill = 1'b1;
        end
      end else if (rtc_sel_ok) begin
        res.target    = TGT_RTC;
        res.rtc_index = st.rtc_select[2:0];
      end else if (32'(ram_off) < EXT_RAM_BYTES) begin
        res.target = TGT_RAM;
        res.physical_address = 23'(ram_off);
        if (item.opcode) begin
          res.store_data   = d;
          res.store_enable = 1'b1;
        end
      end else begin
        res.target = TGT_OPEN;
      end
    end
  end

endmodule

@@ design/cartridge_bank_mapper.sv @@
// Cartridge bank controller (no mapper, MBC1, MBC2, MBC3) on the CPU bus.
// req channel: one bus access per request (opcode 0 read / 1 write, address,
// data). rsp channel: one result per request, in order: target, physical
// offset, RTC register index, store data/enable and event flags.
// Handshake is valid/ready on both channels; a transfer happens when both
// are high at a rising edge.
// Each accepted request passes the input register, then the mapping logic into
// the result register, before its result is valid. Throughput: one request per
// cycle; the result register and input register are both free to move each
// cycle while rsp.ready is high.
// If the receiver stalls, the result holds, the input register still takes
// one more request, and req.ready then drops until rsp moves again.
// Bank registers update when a request passes into the result register, so
// back-to-back writes and reads see each other in order.
// Configuration: APB port, mapper_kind at 0x0, rom_size_log2 at 0x4; write
// only while idle. pready is tied high.
// Reset (rst, synchronous): both stages empty, mapper_kind 0,
// rom_size_log2 15, rom_bank 1, all other bank registers 0.
module cartridge_bank_mapper #(
  parameter int EXT_RAM_BYTES = cbm_pkg::EXT_RAM_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cbm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cbm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  cbm_req_if.sink                         req,
  cbm_rsp_if.source                       rsp
);
  import cbm_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   req_q;
  logic    req_v;
  result_t res_d;
  result_t res_q;
  logic    res_v;
  logic    adv;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mapper_kind   <= MAPPER_NONE;
      cfg.rom_size_log2 <= ROM_LOG2_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAPPER_KIND:   cfg.mapper_kind   <= pwdata[1:0];
        REG_ROM_SIZE_LOG2: cfg.rom_size_log2 <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAPPER_KIND:   prdata = {{(APB_DATA_W-2){1'b0}}, cfg.mapper_kind};
      REG_ROM_SIZE_LOG2: prdata = {{(APB_DATA_W-5){1'b0}}, cfg.rom_size_log2};
      default:           prdata = '0;
    endcase
  end

  assign adv       = ~res_v | rsp.ready;
  assign req.ready = ~req_v | adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_v <= 1'b0;
    end else if (req.ready) begin
      req_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.opcode      <= req.opcode;
      req_q.bus_address <= req.bus_address;
      req_q.bus_data    <= req.bus_data;
    end
  end

  cbm_map #(
    .EXT_RAM_BYTES(EXT_RAM_BYTES)
  ) u_map (
    .cfg     (cfg),
    .st      (st),
    .item    (req_q),
    .res     (res_d),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v               <= 1'b0;
      st.rom_bank         <= 7'd1;
      st.ram_bank         <= 3'd0;
      st.ram_enable       <= 1'b0;
      st.banking_mode     <= 1'b0;
      st.rtc_select       <= 4'd0;
      st.last_latch_write <= 8'd0;
    end else if (adv) begin
      res_v <= req_v;
      if (req_v) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req_v) begin
      res_q <= res_d;
    end
  end

  assign rsp.valid              = res_v;
  assign rsp.target             = res_q.target;
  assign rsp.physical_address   = res_q.physical_address;
  assign rsp.rtc_index          = res_q.rtc_index;
  assign rsp.store_data         = res_q.store_data;
  assign rsp.store_enable       = res_q.store_enable;
  assign rsp.high_nibble_fill   = res_q.high_nibble_fill;
  assign rsp.ram_disabled_event = res_q.ram_disabled_event;
  assign rsp.rtc_latch_strobe   = res_q.rtc_latch_strobe;

endmodule
